// ----- hw/rtl/utf8_to_utf16_transcoder_core_macros.svh -----
`ifndef UTF8_TO_UTF16_TRANSCODER_CORE_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define U8U16_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// condition that must never hold outside reset
`define U8U16_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- hw/rtl/u8u16_pkg.sv -----
`default_nettype none

package u8u16_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [1:0] STATUS_UNIT      = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
    localparam logic [1:0] STATUS_END       = 2'd3;

    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;
    localparam logic [15:0] SURR_HI_BASE       = 16'hd800;
    localparam logic [15:0] SURR_LO_BASE       = 16'hdc00;

    typedef enum logic [1:0] {
        SEQ_NONE  = 2'd0,
        SEQ_TWO   = 2'd1,
        SEQ_THREE = 2'd2,
        SEQ_FOUR  = 2'd3
    } seq_kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } in_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  status;
        logic        end_of_string;
        logic        all_ascii;
        logic        last_of_run;
    } out_item_t;

    // one queue entry: a single beat, or a surrogate pair that expands to two beats
    typedef struct packed {
        logic        pair;
        logic [15:0] unit0;
        logic [15:0] unit1;
        logic [1:0]  status;
        logic        eos;
        logic        ascii;
    } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/utf8_to_utf16_transcoder_core.sv -----
// channel | payload     | handshake            | beat
// src     | in_item_t   | src_valid/src_stall  | one utf-8 byte, string_end on the last
// dst     | out_item_t  | dst_valid/dst_stall  | one utf-16 unit or status
//
// one byte is taken every cycle while the result queue has room
// a surrogate pair gives two output beats from one queue entry; the output stage holds the low beat
// a byte's queue entry is written when the byte is taken, then loaded into the output register for dst
// src_stall rises when all QUEUE_DEPTH queue entries are held
// reset clears the decode state, empties the queue and clears the output valid and pending low beat

`default_nettype none

module utf8_to_utf16_transcoder_core
    import u8u16_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     src_valid,
    output logic          src_stall,
    input  wire in_item_t src_data,
    output logic          dst_valid,
    input  wire logic     dst_stall,
    output out_item_t     dst_data
);

    logic accept;
    logic push;
    logic pop;
    logic empty;
    logic full;
    cmd_t cmd;
    cmd_t head;

    assign src_stall = full;
    assign accept    = src_valid && !full;

    u8u16_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (src_data),
        .push   (push),
        .cmd    (cmd)
    );

    u8u16_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cmd),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    u8u16_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/u8u16_fifo.sv -----
`default_nettype none

`include "utf8_to_utf16_transcoder_core_macros.svh"

module u8u16_fifo
    import u8u16_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    input  wire logic pop,
    output cmd_t      head,
    output logic      empty,
    output logic      full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_FULL);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `U8U16_ASSERT_NEVER(a_no_overflow, push && full, "queue written while full")
    `U8U16_ASSERT_NEVER(a_no_underflow, pop && empty, "queue read while empty")

endmodule

`default_nettype wire

// ----- hw/rtl/u8u16_front.sv -----
`default_nettype none

`include "utf8_to_utf16_transcoder_core_macros.svh"

module u8u16_front
    import u8u16_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire in_item_t item,
    output logic          push,
    output cmd_t          cmd
);

    logic [1:0]  bytes_pending_reg;
    logic [1:0]  bytes_pending_next;
    seq_kind_t   seq_kind_reg;
    seq_kind_t   seq_kind_next;
    logic [20:0] acc_reg;
    logic [20:0] acc_next;
    logic        error_reg;
    logic        error_next;
    logic        high_bit_reg;
    logic        high_bit_next;

    logic [7:0]  b;
    logic        fin;
    logic        ascii;
    logic        lead2;
    logic        lead3;
    logic        lead4;
    logic        cont_ok;
    logic [20:0] acc_shift;
    logic [20:0] supp;

    assign b         = item.in_byte;
    assign fin       = item.string_end;
    assign ascii     = !(high_bit_reg || b[7]);
    assign lead2     = (b[7:5] == 3'b110);
    assign lead3     = (b[7:4] == 4'b1110);
    assign lead4     = (b[7:3] == 5'b11110);
    assign cont_ok   = (b[7:6] == 2'b10);
    assign acc_shift = {acc_reg[14:0], b[5:0]};
    assign supp      = acc_shift - SUPPLEMENTARY_BASE;

    // next state
    always_comb
    begin
        bytes_pending_next = bytes_pending_reg;
        seq_kind_next      = seq_kind_reg;
        acc_next           = acc_reg;
        error_next         = error_reg;
        high_bit_next      = high_bit_reg || b[7];
        if (error_reg)
        begin
            // drop bytes until the final one
        end
        else if (bytes_pending_reg == 2'd0)
        begin
            if (lead2)
            begin
                seq_kind_next      = SEQ_TWO;
                bytes_pending_next = 2'd1;
                acc_next           = {16'b0, b[4:0]};
            end
            else if (lead3)
            begin
                seq_kind_next      = SEQ_THREE;
                bytes_pending_next = 2'd2;
                acc_next           = {16'b0, b[4:0]};
            end
            else if (lead4)
            begin
                seq_kind_next      = SEQ_FOUR;
                bytes_pending_next = 2'd3;
                acc_next           = {18'b0, b[2:0]};
            end
        end
        else if (fin && bytes_pending_reg > 2'd1)
        begin
            // truncated, state is cleared below
        end
        else if (!cont_ok)
        begin
            error_next         = 1'b1;
            bytes_pending_next = 2'd0;
            seq_kind_next      = SEQ_NONE;
            acc_next           = '0;
        end
        else
        begin
            acc_next           = acc_shift;
            bytes_pending_next = bytes_pending_reg - 1'b1;
            if (bytes_pending_reg == 2'd1)
            begin
                seq_kind_next = SEQ_NONE;
                acc_next      = '0;
            end
        end
        if (fin)
        begin
            bytes_pending_next = 2'd0;
            seq_kind_next      = SEQ_NONE;
            acc_next           = '0;
            error_next         = 1'b0;
            high_bit_next      = 1'b0;
        end
    end

    // queue entry for this byte
    always_comb
    begin
        push       = 1'b0;
        cmd.pair   = 1'b0;
        cmd.unit0  = '0;
        cmd.unit1  = '0;
        cmd.status = STATUS_UNIT;
        cmd.eos    = fin;
        cmd.ascii  = fin && ascii;
        if (error_reg)
        begin
            push       = fin;
            cmd.status = STATUS_END;
        end
        else if (bytes_pending_reg == 2'd0)
        begin
            if (!b[7])
            begin
                push      = 1'b1;
                cmd.unit0 = {8'b0, b};
            end
            else if (lead2 || lead3 || lead4)
            begin
                push       = fin;
                cmd.status = STATUS_TRUNCATED;
            end
            else
            begin
                push       = fin;
                cmd.status = STATUS_END;
            end
        end
        else if (fin && bytes_pending_reg > 2'd1)
        begin
            push       = 1'b1;
            cmd.status = STATUS_TRUNCATED;
        end
        else if (!cont_ok)
        begin
            push       = 1'b1;
            cmd.status = STATUS_MALFORMED;
        end
        else if (bytes_pending_reg == 2'd1)
        begin
            push = 1'b1;
            if (seq_kind_reg == SEQ_FOUR)
            begin
                cmd.pair  = 1'b1;
                cmd.unit0 = SURR_HI_BASE | {6'b0, supp[19:10]};
                cmd.unit1 = SURR_LO_BASE | {6'b0, supp[9:0]};
            end
            else
            begin
                cmd.unit0 = acc_shift[15:0];
            end
        end
        push = push && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_pending_reg <= 2'd0;
            seq_kind_reg      <= SEQ_NONE;
            acc_reg           <= '0;
            error_reg         <= 1'b0;
            high_bit_reg      <= 1'b0;
        end
        else if (accept)
        begin
            bytes_pending_reg <= bytes_pending_next;
            seq_kind_reg      <= seq_kind_next;
            acc_reg           <= acc_next;
            error_reg         <= error_next;
            high_bit_reg      <= high_bit_next;
        end
    end

    `U8U16_ASSERT_IMPLY(a_err_clears_seq, error_reg,
        bytes_pending_reg == 2'd0 && seq_kind_reg == SEQ_NONE, "error with sequence open")
    `U8U16_ASSERT_IMPLY(a_pending_has_kind, bytes_pending_reg != 2'd0,
        seq_kind_reg != SEQ_NONE, "bytes pending without a sequence kind")

endmodule

`default_nettype wire

// ----- hw/rtl/u8u16_back.sv -----
`default_nettype none

`include "utf8_to_utf16_transcoder_core_macros.svh"

module u8u16_back
    import u8u16_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t head,
    input  wire logic empty,
    output logic      pop,
    output logic      dst_valid,
    input  wire logic dst_stall,
    output out_item_t dst_data
);

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_reg;
    out_item_t out_next;
    logic      lo_pending_reg;
    logic      lo_pending_next;
    out_item_t lo_reg;
    out_item_t lo_next;
    logic      load;
    out_item_t first_beat;
    out_item_t second_beat;

    assign load = !out_valid_reg || !dst_stall;
    assign pop  = load && !lo_pending_reg && !empty;

    always_comb
    begin
        first_beat.code_unit     = head.unit0;
        first_beat.status        = head.status;
        first_beat.end_of_string = head.pair ? 1'b0 : head.eos;
        first_beat.all_ascii     = head.pair ? 1'b0 : head.ascii;
        first_beat.last_of_run   = !head.pair;

        second_beat.code_unit     = head.unit1;
        second_beat.status        = STATUS_UNIT;
        second_beat.end_of_string = head.eos;
        second_beat.all_ascii     = head.ascii;
        second_beat.last_of_run   = 1'b1;
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        lo_pending_next = lo_pending_reg;
        lo_next         = lo_reg;
        if (load)
        begin
            if (lo_pending_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = lo_reg;
                lo_pending_next = 1'b0;
            end
            else if (!empty)
            begin
                out_valid_next  = 1'b1;
                out_next        = first_beat;
                lo_pending_next = head.pair;
                lo_next         = second_beat;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            lo_pending_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            lo_pending_reg <= lo_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        lo_reg  <= lo_next;
    end

    assign dst_valid = out_valid_reg;
    assign dst_data  = out_reg;

    // the high half of a pair is on the port while the low half waits
    `U8U16_ASSERT_IMPLY(a_lo_after_hi, lo_pending_reg,
        out_valid_reg && !out_reg.last_of_run, "low surrogate queued without high beat")

endmodule

`default_nettype wire
